// ===== src/rpbo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relay port bank package
// Shared types, command and register codes, and the port number decoder.
// ----------------------------------------------------------------------------
package rpbo_pkg;

  localparam int unsigned MaxExpansion = 8;
  localparam int unsigned DefExpansion = 8;
  localparam int unsigned SecsPerMin   = 60;
  // Wide enough for a module index of 0 to MaxExpansion.
  localparam int unsigned ModW         = 4;

  typedef enum logic [3:0] {
    CMD_ON           = 4'd0,
    CMD_OFF          = 4'd1,
    CMD_TOGGLE       = 4'd2,
    CMD_FORCE_OFF    = 4'd3,
    CMD_FORCE_ON     = 4'd4,
    CMD_AUTO         = 4'd5,
    CMD_ALL_ON       = 4'd6,
    CMD_ALL_OFF      = 4'd7,
    CMD_DELAY_ON     = 4'd8,
    CMD_DELAY_ON_DEF = 4'd9,
    CMD_QUERY        = 4'd10
  } cmd_e;

  typedef enum logic {
    CFG_START_TIME = 1'b0,
    CFG_DEF_DELAY  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0]  command;
    logic [6:0]  port_id;
    logic [7:0]  delay_minutes;
    logic [31:0] time_now;
  } in_word_t;

  typedef struct packed {
    logic       port_on;
    logic       forced_on;
    logic       forced_off;
    logic [7:0] drive_byte;
    logic       port_valid;
  } out_word_t;

  // One module's state as held in the bank memory.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] mask_on;
    logic [7:0] mask_off;
    logic [7:0] marks;
  } entry_t;

  localparam entry_t ResetEntry = '{
    data:     8'h00,
    mask_on:  8'h00,
    mask_off: 8'hFF,
    marks:    8'h00
  };

  typedef struct packed {
    logic            ok;
    logic [ModW-1:0] mod;
    logic [2:0]      bit_idx;
  } dec_t;

  typedef struct packed {
    logic            en;
    logic [ModW-1:0] mod;
  } rd_req_t;

  typedef struct packed {
    logic            en;
    logic [ModW-1:0] mod;
    entry_t          entry;
    logic            fill_en;
    logic            fill_on;
  } wr_req_t;

  // Port 1-8 is the main module; 11-88 is expansion module tens, bit ones-1.
  function automatic dec_t decode_port(input logic [6:0] id,
                                       input logic [ModW-1:0] exp_mods);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    dec_t        d;
    // Multiply by 205/2048 gives id/10 exactly over the 7-bit range.
    prod = 15'(id) * 15'd205;
    tens = prod[14:11];
    ones = id - 7'(tens) * 7'd10;
    d = '{ok: 1'b0, mod: '0, bit_idx: '0};
    if (id inside {[7'd1:7'd8]}) begin
      d.ok      = 1'b1;
      d.bit_idx = 3'(id - 7'd1);
    end else if (id inside {[7'd11:7'd88]} && ones inside {[7'd1:7'd8]} &&
                 tens <= exp_mods) begin
      d.ok      = 1'b1;
      d.mod     = tens;
      d.bit_idx = 3'(ones - 7'd1);
    end
    return d;
  endfunction

endpackage

// ===== src/rpbo_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relay port bank store
// Synchronous module memory with per-entry valid bits and a bank-wide
// data fill used by the all-on and all-off commands.
// ----------------------------------------------------------------------------
module rpbo_store import rpbo_pkg::*; #(
  parameter int unsigned NumModules = DefExpansion + 1
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  rd_req_t rd_req_i,
  output entry_t  rd_entry_o,
  input  wr_req_t wr_req_i
);

  localparam int unsigned AddrW = (NumModules > 1) ? $clog2(NumModules) : 1;

  entry_t                  mem_q [NumModules];
  entry_t                  rd_data_q;
  logic [AddrW-1:0]        rd_addr_q;
  logic [NumModules-1:0]   valid_q;
  logic [NumModules-1:0]   fill_q;
  logic                    fill_on_q;
  logic [AddrW-1:0]        rd_addr;
  logic [AddrW-1:0]        wr_addr;
  entry_t                  base_entry;

  assign rd_addr = rd_req_i.mod[AddrW-1:0];
  assign wr_addr = wr_req_i.mod[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_req_i.en) begin
      mem_q[wr_addr] <= wr_req_i.entry;
    end
    if (rd_req_i.en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // An entry never written reads as its reset value; a pending fill
  // overrides the data byte until the entry is written back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      fill_q    <= '0;
      fill_on_q <= 1'b0;
    end else begin
      if (wr_req_i.en) begin
        valid_q[wr_addr] <= 1'b1;
        fill_q[wr_addr]  <= 1'b0;
      end
      if (wr_req_i.fill_en) begin
        fill_q    <= '1;
        fill_on_q <= wr_req_i.fill_on;
      end
    end
  end

  always_comb begin
    base_entry = valid_q[rd_addr_q] ? rd_data_q : ResetEntry;
    rd_entry_o = base_entry;
    if (fill_q[rd_addr_q]) begin
      rd_entry_o.data = {8{fill_on_q}};
    end
  end

endmodule

// ===== src/rpbo_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relay port bank command unit
// Decodes a command word, modifies the addressed module entry read from the
// store, writes it back and registers the result word.
// ----------------------------------------------------------------------------
module rpbo_exec import rpbo_pkg::*; #(
  parameter int unsigned ExpansionModules = DefExpansion
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  input  logic [31:0] start_time_i,
  input  logic [7:0]  def_delay_i,
  output rd_req_t     rd_req_o,
  input  entry_t      rd_entry_i,
  output wr_req_t     wr_req_o
);

  logic        busy_q;
  logic        out_valid_q;
  cmd_e        cmd_q;
  dec_t        dec_q;
  logic [7:0]  dmin_q;
  logic [31:0] now_q;
  out_word_t   out_q;

  dec_t        in_dec;
  logic        accept;
  logic        out_load;
  logic [7:0]  bm;
  logic [7:0]  minutes;
  logic [13:0] limit;
  logic        late;
  entry_t      nxt;
  logic        port_wr;
  logic        fill_en;
  logic        fill_on;
  logic [7:0]  eff;
  out_word_t   res;

  assign in_dec   = decode_port(in_word_i.port_id, ModW'(ExpansionModules));
  // The store is read at acceptance and written when the result is loaded,
  // so a second word waits until the write-back is done.
  assign accept   = in_valid_i && !busy_q;
  assign out_load = busy_q && (!out_valid_q || !out_stall_i);

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign rd_req_o = '{en: accept, mod: in_dec.mod};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (out_load) begin
        busy_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_e'(in_word_i.command);
      dec_q  <= in_dec;
      dmin_q <= in_word_i.delay_minutes;
      now_q  <= in_word_i.time_now;
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  always_comb begin
    bm      = dec_q.ok ? (8'd1 << dec_q.bit_idx) : 8'd0;
    minutes = (cmd_q == CMD_DELAY_ON_DEF) ? def_delay_i : dmin_q;
    limit   = 14'(minutes) * 14'(SecsPerMin);
    // Elapsed time wraps modulo 2^32.
    late    = (now_q - start_time_i) > 32'(limit);
    nxt     = rd_entry_i;
    port_wr = 1'b1;
    fill_en = 1'b0;
    fill_on = 1'b0;
    case (cmd_q)
      CMD_ON:     nxt.data = nxt.data | bm;
      CMD_OFF:    nxt.data = nxt.data & ~bm;
      CMD_TOGGLE: nxt.data = nxt.data ^ bm;
      CMD_FORCE_OFF: begin
        nxt.mask_on  = nxt.mask_on & ~bm;
        nxt.mask_off = nxt.mask_off & ~bm;
      end
      CMD_FORCE_ON: begin
        nxt.mask_on  = nxt.mask_on | bm;
        nxt.mask_off = nxt.mask_off | bm;
      end
      CMD_AUTO: begin
        nxt.mask_on  = nxt.mask_on & ~bm;
        nxt.mask_off = nxt.mask_off | bm;
      end
      CMD_ALL_ON: begin
        nxt.data = 8'hFF;
        port_wr  = 1'b0;
        fill_en  = 1'b1;
        fill_on  = 1'b1;
      end
      CMD_ALL_OFF: begin
        nxt.data = 8'h00;
        port_wr  = 1'b0;
        fill_en  = 1'b1;
      end
      CMD_DELAY_ON, CMD_DELAY_ON_DEF: begin
        nxt.marks = nxt.marks | bm;
        if (late) begin
          nxt.data = nxt.data | bm;
        end
      end
      default: ;
    endcase

    eff = (nxt.data & nxt.mask_off) | nxt.mask_on;
    res = '0;
    if (dec_q.ok) begin
      res.port_on    = eff[dec_q.bit_idx];
      res.forced_on  = nxt.mask_on[dec_q.bit_idx];
      res.forced_off = ~nxt.mask_off[dec_q.bit_idx];
      res.drive_byte = ~eff;
      res.port_valid = 1'b1;
    end
  end

  assign wr_req_o = '{
    en:      out_load && dec_q.ok && port_wr,
    mod:     dec_q.mod,
    entry:   nxt,
    fill_en: out_load && fill_en,
    fill_on: fill_on
  };

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("accepted word did not start the command unit");

  a_hold_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !out_load |=> busy_q && $stable(cmd_q) && $stable(dec_q))
    else $error("command stage changed while waiting on the output");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q))
    else $error("result word appeared without a command in flight");

  a_write_valid_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_req_o.en |-> dec_q.ok && !wr_req_o.fill_en)
    else $error("entry write-back for an invalid port or during a fill");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.port_valid |-> out_q.drive_byte == 8'h00 &&
      !out_q.port_on && !out_q.forced_on && !out_q.forced_off)
    else $error("invalid port result carries nonzero fields");

endmodule

// ===== src/relay_port_bank_with_override_unit.sv =====
`timescale 1ns / 1ps
// Pipeline: an accepted command word is registered with its module entry read from
// the memory; the entry is modified and written back and the result word registered
// when the output can take it. The next word waits for that write-back, so the unit
// takes no new word while one is in flight. A stalled output holds the unit longer.
// Reset: asynchronous; entries read as their reset values through valid bits,
// with no clearing pass, and both configuration registers reset to zero.
// ----------------------------------------------------------------------------
// Relay port bank with override
// Main module plus expansion modules of eight relay ports each, with data,
// force-on and force-off masks and delayed-on marks per module.
// ----------------------------------------------------------------------------
module relay_port_bank_with_override_unit import rpbo_pkg::*; #(
  parameter int unsigned ExpansionModules = DefExpansion
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [31:0] start_time_q;
  logic [7:0]  def_delay_q;
  rd_req_t     rd_req;
  entry_t      rd_entry;
  wr_req_t     wr_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_time_q <= '0;
      def_delay_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_START_TIME: start_time_q <= cfg_wdata_i;
        CFG_DEF_DELAY:  def_delay_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  rpbo_exec #(
    .ExpansionModules(ExpansionModules)
  ) u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .start_time_i(start_time_q),
    .def_delay_i (def_delay_q),
    .rd_req_o    (rd_req),
    .rd_entry_i  (rd_entry),
    .wr_req_o    (wr_req)
  );

  rpbo_store #(
    .NumModules(ExpansionModules + 1)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_req_i  (rd_req),
    .rd_entry_o(rd_entry),
    .wr_req_i  (wr_req)
  );

endmodule
